[sv/kf_pkg.sv]
// Shared types and constants for the scalar Kalman filter.
// Used by kf_div, kf_smul and scalar_kalman_filter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kf_pkg;

    localparam int DATA_W    = 32;              // Q16.16 words
    localparam int FRAC_BITS = 16;
    localparam int GAIN_W    = FRAC_BITS + 1;   // gain of exactly 1.0 must fit
    localparam int DIFF_W    = DATA_W + 1;      // z - x and its magnitude
    localparam int DEN_W     = DATA_W + 1;      // prior + R
    localparam int CNT_W     = $clog2(GAIN_W);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(GAIN_W - 1);

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_PROCESS_NOISE     = 1'b0;
    localparam t_cfg_idx REG_MEASUREMENT_NOISE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MLOAD,
        S_MUL,
        S_FIN
    } t_state;

    // sequencing for the serial units
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctl;

endpackage

`default_nettype wire

[sv/kf_div.sv]
// Restoring divider, one quotient bit per step, MSB first.
// Quotient = floor(dividend * 2^FRAC_BITS / divisor); uses kf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kf_div #(
    parameter int NUM_W = kf_pkg::DATA_W,
    parameter int DEN_W = kf_pkg::DEN_W,
    parameter int Q_W   = kf_pkg::GAIN_W
) (
    input  wire logic             i_clk,
    input  wire kf_pkg::t_ser_ctl i_ctl,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic      [Q_W-1:0]   o_quotient
);
    import kf_pkg::*;

    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic             r_first;
    logic [REM_W-1:0] trial;
    logic             ge;

    // first step tests the unshifted dividend: that gives the integer bit
    assign trial = r_first ? r_rem : {r_rem[REM_W-2:0], 1'b0};
    assign ge    = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem   <= REM_W'(i_dividend);
            r_q     <= '0;
            r_first <= 1'b1;
        end else if (i_ctl.step) begin
            r_rem   <= ge ? (trial - {1'b0, i_divisor}) : trial;
            r_q     <= {r_q[Q_W-2:0], ge};
            r_first <= 1'b0;
        end
    end

    assign o_quotient = r_q;

endmodule

`default_nettype wire

[sv/kf_smul.sv]
// Shift-add multiplier, one multiplier bit per step, LSB first.
// Gives product >> (ML_W - 1) after ML_W steps; uses kf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kf_smul #(
    parameter int MC_W = kf_pkg::DIFF_W,
    parameter int ML_W = kf_pkg::GAIN_W
) (
    input  wire logic             i_clk,
    input  wire kf_pkg::t_ser_ctl i_ctl,
    input  wire logic [MC_W-1:0]  i_mcand,
    input  wire logic [ML_W-1:0]  i_mplier,
    output logic      [MC_W:0]    o_prod_hi
);
    import kf_pkg::*;

    logic [MC_W-1:0] r_mc;
    logic [ML_W-1:0] r_ml;
    logic [MC_W-1:0] r_acc;
    logic            r_out_bit;
    logic [MC_W:0]   sum;

    // upper partial sum only; low bits fall out one per step
    assign sum = {1'b0, r_acc} + (r_ml[0] ? {1'b0, r_mc} : '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mc      <= i_mcand;
            r_ml      <= i_mplier;
            r_acc     <= '0;
            r_out_bit <= 1'b0;
        end else if (i_ctl.step) begin
            r_acc     <= sum[MC_W:1];
            r_out_bit <= sum[0];
            r_ml      <= r_ml >> 1;
        end
    end

    assign o_prod_hi = {r_acc, r_out_bit};

endmodule

`default_nettype wire

[sv/scalar_kalman_filter.sv]
// Scalar Kalman filter (A = 1, H = 1), Q16.16 fixed point, bit-serial datapath.
// Depends on kf_pkg, kf_div and kf_smul.
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Handshake                  Payload
// -----------  ---------  -------------------------  -------------------------
// measurement  in         i_in_valid / o_in_stall    i_measurement  s32 Q16.16
// estimate     out        o_out_valid / i_out_stall  o_estimate     s32 Q16.16
// config       in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// After the input transfer the filter runs a prep step, 17 divider steps for
// the gain, a load, 17 shift-add steps (both products run side by side, one on
// the gain and one on 1 - gain) and a finish step that raises o_out_valid.
// Synchronous active-low reset clears state to estimate 0, covariance 0 and
// the noise registers to 20.0 and 200.0.
// The input is taken only in idle; a finished result sits in the output
// register while the next measurement transfers, and the finish step waits
// if the previous result is still stalled there.

module scalar_kalman_filter (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // measurement channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [kf_pkg::DATA_W-1:0] i_measurement,
    // estimate channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [kf_pkg::DATA_W-1:0] o_estimate,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire kf_pkg::t_cfg_idx          i_cfg_index,
    input  wire logic [kf_pkg::DATA_W-1:0] i_cfg_data
);
    import kf_pkg::*;

    localparam logic [DATA_W-1:0] Q_RESET = DATA_W'(1310720);
    localparam logic [DATA_W-1:0] R_RESET = DATA_W'(13107200);

    // state and configuration
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DATA_W-1:0]   r_q_noise;
    logic [DATA_W-1:0]   r_r_noise;
    logic [DATA_W-1:0]   r_est;
    logic [DATA_W-1:0]   r_cov;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_est;

    // per-item working registers
    logic [DATA_W-1:0]   r_prior;
    logic [DIFF_W-1:0]   r_diff;
    logic [DEN_W-1:0]    r_denom;
    logic                r_dz;
    logic                r_neg;
    logic [DIFF_W-1:0]   r_mag;

    t_ser_ctl            div_ctl, mul_ctl;
    logic                in_xfer, out_xfer, fin_fire;
    logic [DATA_W:0]     sum_pq;
    logic [DATA_W-1:0]   prior_sat;
    logic [DIFF_W-1:0]   diff;
    logic [GAIN_W-1:0]   quot, gain;
    logic [DIFF_W:0]     est_prod;
    logic [DATA_W:0]     cov_prod;
    logic [DIFF_W-1:0]   dmag;
    logic [DIFF_W-1:0]   x_new;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;

    // prior = P + Q, saturating at all ones
    assign sum_pq    = {1'b0, r_cov} + {1'b0, r_q_noise};
    assign prior_sat = sum_pq[DATA_W] ? '1 : sum_pq[DATA_W-1:0];
    assign diff      = {i_measurement[DATA_W-1], i_measurement} - {r_est[DATA_W-1], r_est};

    // zero divisor forces zero gain
    assign gain = r_dz ? '0 : quot;
    assign dmag = est_prod[DIFF_W-1:0];

    // x + sign(diff) * dmag with one adder: invert and carry in when negative
    assign x_new = {r_est[DATA_W-1], r_est} + (r_neg ? ~dmag : dmag) + DIFF_W'(r_neg);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        div_ctl    = '0;
        mul_ctl    = '0;
        fin_fire   = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                div_ctl.load = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                div_ctl.step = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) n_state = S_MLOAD;
            end
            S_MLOAD: begin
                mul_ctl.load = 1'b1;
                n_cnt        = '0;
                n_state      = S_MUL;
            end
            S_MUL: begin
                mul_ctl.step = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) n_state = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    fin_fire = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_est       <= '0;
            r_cov       <= '0;
            r_q_noise   <= Q_RESET;
            r_r_noise   <= R_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PROCESS_NOISE:     r_q_noise <= i_cfg_data;
                    REG_MEASUREMENT_NOISE: r_r_noise <= i_cfg_data;
                    default: ;
                endcase
            end
            if (fin_fire) begin
                r_est       <= x_new[DATA_W-1:0];
                r_cov       <= cov_prod[DATA_W-1:0];
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_prior <= prior_sat;
            r_diff  <= diff;
        end
        if (r_state == S_PREP) begin
            r_denom <= {1'b0, r_prior} + {1'b0, r_r_noise};
            r_dz    <= (r_prior == '0) && (r_r_noise == '0);
            r_neg   <= r_diff[DIFF_W-1];
            r_mag   <= r_diff[DIFF_W-1] ? (~r_diff + DIFF_W'(1)) : r_diff;
        end
        if (fin_fire) r_out_est <= x_new[DATA_W-1:0];
    end

    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out_est;

    // gain = floor(prior * 2^16 / (prior + R))
    kf_div #(
        .NUM_W (DATA_W),
        .DEN_W (DEN_W),
        .Q_W   (GAIN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (r_prior),
        .i_divisor  (r_denom),
        .o_quotient (quot)
    );

    // |diff| * gain >> 16
    kf_smul #(
        .MC_W (DIFF_W),
        .ML_W (GAIN_W)
    ) u_mul_est (
        .i_clk     (i_clk),
        .i_ctl     (mul_ctl),
        .i_mcand   (r_mag),
        .i_mplier  (gain),
        .o_prod_hi (est_prod)
    );

    // prior * (1 - gain) >> 16
    kf_smul #(
        .MC_W (DATA_W),
        .ML_W (GAIN_W)
    ) u_mul_cov (
        .i_clk     (i_clk),
        .i_ctl     (mul_ctl),
        .i_mcand   (r_prior),
        .i_mplier  (GAIN_ONE - gain),
        .o_prod_hi (cov_prod)
    );

    // gain never exceeds 1.0 when the products start
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MLOAD) |-> (gain <= GAIN_ONE))
        else $error("gain above one");

    // posterior covariance never exceeds the prior it came from
    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_fire |=> (r_cov <= $past(r_prior)))
        else $error("covariance grew in update");

    // a result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !fin_fire)
        else $error("result overwritten");

    // input is only taken with the serial units at rest
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_PREP))
        else $error("transfer outside idle");

endmodule

`default_nettype wire
